@@ rtl/txr_pkg.sv @@
package txr_pkg;

    localparam int RING_DEPTH = 256;
    localparam int SPAN_MAX   = 32;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int LEN_W  = 6;
    localparam int DATA_W = 8;
    localparam int IDX_W  = 8;
    localparam int CTR_W  = 32;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_DONE  = 3'd1,
        OP_FAULT = 3'd2,
        OP_KICK  = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  data_byte;
        logic               end_of_write;
        logic [IDX_W-1:0]   read_index;
    } t_cmd;

    typedef struct packed {
        logic               span_start_valid;
        logic [7:0]         span_start;
        logic [LEN_W-1:0]   span_length;
        logic               transfer_active;
        logic [7:0]         pending_bytes;
        logic [CTR_W-1:0]   dropped_bytes;
        logic [CTR_W-1:0]   blocks_done;
        logic [CTR_W-1:0]   transfer_errors;
        logic [DATA_W-1:0]  read_byte;
    } t_rsp;

endpackage

@@ rtl/tx_ring_dma_span_scheduler_unit.sv @@
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+----------------------
// command   | in        | start, busy                 | i_cmd  (txr_pkg::t_cmd)
// response  | out       | o_rsp_strobe (one cycle)    | o_rsp  (txr_pkg::t_rsp)
// config    | in        | i_cfg_valid, o_cfg_ready    | i_cfg_data (transfer enable)
//
// a command transaction is taken whenever start is high; busy stays low, so one
// item per cycle is sustained
// its response appears for one cycle in the cycle right after acceptance; the
// response is registered, and its read byte comes from the registered ring read port
// synchronous active-low reset clears pointers, span state and counters and sets
// transfer enable; the ring memory itself is not cleared and needs no sweep
// the receiver cannot stall: every response is taken in the cycle it is shown
module tx_ring_dma_span_scheduler_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  txr_pkg::t_cmd i_cmd,
    output logic          o_rsp_strobe,
    output txr_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam logic [txr_pkg::CNT_W-1:0] DEPTH_C = txr_pkg::CNT_W'(txr_pkg::RING_DEPTH);
    localparam logic [txr_pkg::CNT_W-1:0] SPAN_C  = txr_pkg::CNT_W'(txr_pkg::SPAN_MAX);

    // architectural state
    logic [txr_pkg::PTR_W-1:0] r_wp, n_wp;
    logic [txr_pkg::PTR_W-1:0] r_rp, n_rp;
    logic                      r_act, n_act;
    logic [txr_pkg::LEN_W-1:0] r_flen, n_flen;
    logic [txr_pkg::CTR_W-1:0] r_drop, n_drop;
    logic [txr_pkg::CTR_W-1:0] r_blk, n_blk;
    logic [txr_pkg::CTR_W-1:0] r_err, n_err;
    logic                      r_en;

    // per-response registers
    logic                      r_strobe;
    logic                      r_started, n_started;
    logic [txr_pkg::PTR_W-1:0] r_sstart, n_sstart;
    logic [txr_pkg::LEN_W-1:0] r_slen, n_slen;
    logic                      r_rd_sel;

    logic                       accept;
    logic                       cfg_wr;
    logic                       ram_we;
    logic                       ram_re;
    logic [txr_pkg::DATA_W-1:0] ram_q;
    logic                       has_space;
    logic                       try_go;

    // modular add of a span length to a ring position
    function automatic logic [txr_pkg::PTR_W-1:0] wrap_add(
        input logic [txr_pkg::PTR_W-1:0] pos,
        input logic [txr_pkg::LEN_W-1:0] amt
    );
        logic [txr_pkg::CNT_W-1:0] sum;
        sum = {1'b0, pos} + txr_pkg::CNT_W'(amt);
        if (sum >= DEPTH_C) begin
            sum = sum - DEPTH_C;
        end
        return sum[txr_pkg::PTR_W-1:0];
    endfunction

    function automatic logic [txr_pkg::CNT_W-1:0] occupancy(
        input logic [txr_pkg::PTR_W-1:0] wp,
        input logic [txr_pkg::PTR_W-1:0] rp
    );
        logic [txr_pkg::CNT_W-1:0] cnt;
        if (wp >= rp) begin
            cnt = {1'b0, wp} - {1'b0, rp};
        end else begin
            cnt = DEPTH_C - {1'b0, rp} + {1'b0, wp};
        end
        return cnt;
    endfunction

    assign accept      = start && !busy;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign has_space   = (occupancy(r_wp, r_rp) + txr_pkg::CNT_W'(1)) < DEPTH_C;
    assign ram_we      = accept && (i_cmd.op == txr_pkg::OP_WRITE) && has_space;
    assign ram_re      = accept && (i_cmd.op == txr_pkg::OP_READ);

    txr_ring_ram #(
        .DEPTH (txr_pkg::RING_DEPTH),
        .WIDTH (txr_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_cmd.data_byte),
        .i_re    (ram_re),
        .i_raddr (i_cmd.read_index[txr_pkg::PTR_W-1:0]),
        .o_rdata (ram_q)
    );

    // next-state: op effects first, then the optional span start on the result
    always_comb begin
        logic [txr_pkg::CNT_W-1:0] len;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_act     = r_act;
        n_flen    = r_flen;
        n_drop    = r_drop;
        n_blk     = r_blk;
        n_err     = r_err;
        try_go    = 1'b0;
        n_started = 1'b0;
        n_sstart  = '0;
        n_slen    = '0;
        len       = '0;

        case (i_cmd.op)
            txr_pkg::OP_WRITE: begin
                if (has_space) begin
                    n_wp = wrap_add(r_wp, txr_pkg::LEN_W'(1));
                end else begin
                    n_drop = r_drop + txr_pkg::CTR_W'(1);
                end
                // a refused last byte still tries a start
                try_go = i_cmd.end_of_write;
            end
            txr_pkg::OP_DONE: begin
                if (!r_act || r_flen == '0) begin
                    // done without a span in flight
                    n_err = r_err + txr_pkg::CTR_W'(1);
                end else begin
                    n_rp   = wrap_add(r_rp, r_flen);
                    n_flen = '0;
                    n_act  = 1'b0;
                    n_blk  = r_blk + txr_pkg::CTR_W'(1);
                    try_go = 1'b1;
                end
            end
            txr_pkg::OP_FAULT: begin
                n_err = r_err + txr_pkg::CTR_W'(1);
                if (r_act && r_flen != '0) begin
                    n_rp   = wrap_add(r_rp, r_flen);
                    n_drop = r_drop + txr_pkg::CTR_W'(r_flen);
                end
                n_flen = '0;
                n_act  = 1'b0;
                try_go = 1'b1;
            end
            txr_pkg::OP_KICK: begin
                try_go = 1'b1;
            end
            default: begin
            end
        endcase

        if (try_go && r_en && !n_act && (n_rp != n_wp)) begin
            // contiguous run up to head or ring end, capped at SPAN_MAX
            if (n_wp > n_rp) begin
                len = {1'b0, n_wp} - {1'b0, n_rp};
            end else begin
                len = DEPTH_C - {1'b0, n_rp};
            end
            if (len > SPAN_C) begin
                len = SPAN_C;
            end
            n_act     = 1'b1;
            n_flen    = len[txr_pkg::LEN_W-1:0];
            n_started = 1'b1;
            n_sstart  = n_rp;
            n_slen    = len[txr_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_act    <= 1'b0;
            r_flen   <= '0;
            r_drop   <= '0;
            r_blk    <= '0;
            r_err    <= '0;
            r_en     <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_act  <= n_act;
                r_flen <= n_flen;
                r_drop <= n_drop;
                r_blk  <= n_blk;
                r_err  <= n_err;
            end
            if (cfg_wr) begin
                r_en <= i_cfg_data;
            end
        end
    end

    // response payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_started <= n_started;
            r_sstart  <= n_sstart;
            r_slen    <= n_slen;
            r_rd_sel  <= (i_cmd.op == txr_pkg::OP_READ)
                         && ({1'b0, i_cmd.read_index} < DEPTH_C);
        end
    end

    // status fields come straight from the state, which holds the post-item
    // values for the whole response cycle
    always_comb begin
        logic [txr_pkg::CNT_W-1:0] pend;
        pend                  = occupancy(r_wp, r_rp);
        o_rsp.span_start_valid = r_started;
        o_rsp.span_start       = 8'(r_sstart);
        o_rsp.span_length      = r_slen;
        o_rsp.transfer_active  = r_act;
        o_rsp.pending_bytes    = pend[7:0];
        o_rsp.dropped_bytes    = r_drop;
        o_rsp.blocks_done      = r_blk;
        o_rsp.transfer_errors  = r_err;
        o_rsp.read_byte        = r_rd_sel ? ram_q : '0;
    end

    assign o_rsp_strobe = r_strobe;

`ifndef SYNTH
    // every accepted command gets its response in the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_rsp_strobe)
        else $error("response missing after accepted command");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_rsp_strobe)
        else $error("response without a command");

    // a started span is in flight and has a legal length
    a_span_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_strobe && o_rsp.span_start_valid) |->
            (o_rsp.transfer_active && o_rsp.span_length != '0
             && o_rsp.span_length <= txr_pkg::LEN_W'(txr_pkg::SPAN_MAX)))
        else $error("bad span start");

    // in-flight flag and flight length move together
    a_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act == (r_flen != '0))
        else $error("flight length out of step with active flag");

    // ring data only shows up for a read command
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_strobe && o_rsp.read_byte != '0) |->
            $past(i_cmd.op == txr_pkg::OP_READ))
        else $error("read byte on a non-read response");
`endif

endmodule

@@ rtl/txr_ring_ram.sv @@
module txr_ring_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-edge collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
